@@ rtl/core/foe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foe_pkg
// Shared types, codes and character tables of the order message encoder.
// ----------------------------------------------------------------------------
package foe_pkg;

	localparam logic [1:0] OP_TEXT    = 2'd0;
	localparam logic [1:0] OP_END     = 2'd1;
	localparam logic [1:0] OP_VALUE   = 2'd2;
	localparam logic [1:0] OP_ILLEGAL = 2'd3;

	typedef enum logic [1:0] {KIND_TEXT, KIND_NUM, KIND_CHAR, KIND_PRICE} kind_t;

	localparam logic [3:0] FP_SENDER = 4'd0;
	localparam logic [3:0] FP_SYMBOL = 4'd5;
	localparam logic [3:0] FP_LAST   = 4'd11;

	localparam logic [9:0] BODY_MIN     = 10'd100;
	localparam logic [9:0] BODY_MAX     = 10'd999;
	localparam logic [9:0] HEADER_BYTES = 10'd16;
	localparam logic [9:0] OFF_LEN      = 10'd12;
	localparam logic [9:0] OFF_HSOH     = 10'd15;
	localparam logic [9:0] OFF_CK       = 10'd3;
	localparam logic [9:0] OFF_TSOH     = 10'd6;

	localparam logic [7:0] CH_SOH  = 8'h01;
	localparam logic [7:0] CH_EQ   = "=";
	localparam logic [7:0] CH_DOT  = ".";
	localparam logic [7:0] CH_ZERO = "0";

	typedef enum logic [1:0] {BS_CONST, BS_INPUT, BS_DIGIT} byte_src_t;
	typedef enum logic [1:0] {OS_BODY, OS_FIXED, OS_TRAIL} off_src_t;
	typedef enum logic [1:0] {CV_NUM, CV_PRICE, CV_LEN, CV_CK} conv_sel_t;

	typedef struct packed {
		logic       latch_in;
		logic       push;
		logic       is_body;
		logic       add_sum;
		byte_src_t  byte_src;
		logic [7:0] const_byte;
		off_src_t   off_src;
		logic [9:0] off_k;
		logic       msg_end;
		logic       len_err;
		logic       flush;
		logic       clr_msg;
		logic       fp_inc;
		logic       prefix_set;
		logic       prefix_clr;
		logic       conv_start;
		conv_sel_t  conv_sel;
		logic       dig_init;
		logic       dig_dec;
	} foe_cmd_t;

	typedef struct packed {
		logic       can_push;
		logic       hold_valid;
		logic       conv_busy;
		logic [1:0] opcode;
		logic [3:0] fp;
		logic       prefix_written;
		logic       overflow;
		logic       count_lt_min;
		logic [3:0] digit;
		logic       idx_zero;
		logic       idx_le2;
		logic       idx_le4;
		logic       idx_eq4;
	} foe_status_t;

	function automatic kind_t kind_of(input logic [3:0] fp);
		kind_t k;
		case (fp)
			4'd2, 4'd8:        k = KIND_NUM;
			4'd6, 4'd9, 4'd11: k = KIND_CHAR;
			4'd10:             k = KIND_PRICE;
			default:           k = KIND_TEXT;
		endcase
		return k;
	endfunction

	// tag digits: 49 56 34 52 11 55 54 60 38 40 44 59
	function automatic logic [7:0] tag_char(input logic [3:0] fp, input logic ones);
		logic [7:0] t;
		logic [7:0] o;
		case (fp)
			4'd0:    begin t = "4"; o = "9"; end
			4'd1:    begin t = "5"; o = "6"; end
			4'd2:    begin t = "3"; o = "4"; end
			4'd3:    begin t = "5"; o = "2"; end
			4'd4:    begin t = "1"; o = "1"; end
			4'd5:    begin t = "5"; o = "5"; end
			4'd6:    begin t = "5"; o = "4"; end
			4'd7:    begin t = "6"; o = "0"; end
			4'd8:    begin t = "3"; o = "8"; end
			4'd9:    begin t = "4"; o = "0"; end
			4'd10:   begin t = "4"; o = "4"; end
			default: begin t = "5"; o = "9"; end
		endcase
		return ones ? o : t;
	endfunction

	// field prefix: optional "35=D<SOH>" or "21=1<SOH>", tag, '='
	function automatic logic [7:0] pre_char(input logic [3:0] fp, input logic [2:0] j);
		logic [7:0] c;
		case (j)
			3'd0:    c = (fp == FP_SENDER) ? "3" : "2";
			3'd1:    c = (fp == FP_SENDER) ? "5" : "1";
			3'd2:    c = CH_EQ;
			3'd3:    c = (fp == FP_SENDER) ? "D" : "1";
			3'd4:    c = CH_SOH;
			3'd5:    c = tag_char(fp, 1'b0);
			3'd6:    c = tag_char(fp, 1'b1);
			default: c = CH_EQ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] head_char(input logic [3:0] k);
		logic [7:0] c;
		case (k)
			4'd0:    c = "8";
			4'd1:    c = CH_EQ;
			4'd2:    c = "F";
			4'd3:    c = "I";
			4'd4:    c = "X";
			4'd5:    c = CH_DOT;
			4'd6:    c = "4";
			4'd7:    c = CH_DOT;
			4'd8:    c = "4";
			4'd9:    c = CH_SOH;
			4'd10:   c = "9";
			default: c = CH_EQ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] trail_char(input logic [3:0] k);
		logic [7:0] c;
		case (k)
			4'd0:    c = "1";
			4'd1:    c = CH_ZERO;
			default: c = CH_EQ;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/foe_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foe_if
// Input and output channels of the order message encoder.
// ----------------------------------------------------------------------------
interface foe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [47:0] value;
	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

interface foe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [9:0] offset;
	logic       run_last;
	logic       message_end;
	logic       length_error;
	modport source (output valid, output data_byte, output offset, output run_last,
		output message_end, output length_error, input ready);
	modport sink (input valid, input data_byte, input offset, input run_last,
		input message_end, input length_error, output ready);
endinterface

@@ rtl/core/fix_order_message_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fix_order_message_encoder
// FIX 4.4 NewOrderSingle encoder: field values in, wire bytes with offsets out.
// ----------------------------------------------------------------------------
// One item is taken at a time; the input is held off until the item's results
// are out. A text byte goes through accept, decode, byte and close, with any
// inserted prefix bytes (up to eight on the first byte of a field) between
// decode and byte. Numbers and prices go through a binary to BCD
// shift-and-add-3 unit, then every BCD digit position is scanned (leading
// zeros are scanned but not emitted), with a decimal point inside a price and
// then the SOH. The last field also runs the unit twice more, for the body
// length and the checksum, and emits 16 header and 7 trailer bytes. Results
// leave through a one-deep hold and an output register; while both are full
// the sequencer waits, so a result held up at the output stalls the next
// item.
// ----------------------------------------------------------------------------
module fix_order_message_encoder
	import foe_pkg::*;
#(
	parameter int VALUE_BITS = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	foe_in_if.sink          item_in,
	foe_out_if.source       item_out
);

	foe_cmd_t    cmd;
	foe_status_t st;

	foe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	foe_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_opcode        (item_in.opcode),
		.in_value         (item_in.value),
		.out_valid        (item_out.valid),
		.out_ready        (item_out.ready),
		.out_data_byte    (item_out.data_byte),
		.out_offset       (item_out.offset),
		.out_run_last     (item_out.run_last),
		.out_message_end  (item_out.message_end),
		.out_length_error (item_out.length_error)
	);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.message_end |-> item_out.run_last)
		else $error("message end without run_last");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.length_error |->
		item_out.message_end && item_out.data_byte == 8'd0 && item_out.offset == 10'd0)
		else $error("malformed error result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> !item_in.ready)
		else $error("second item taken while busy");

endmodule

@@ rtl/core/foe_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foe_dpath
// Message state, binary to BCD converter, byte/offset mux and output stage.
// ----------------------------------------------------------------------------
module foe_dpath
	import foe_pkg::*;
#(
	parameter int VALUE_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  foe_cmd_t    cmd,
	output foe_status_t st,
	input  logic [1:0]  in_opcode,
	input  logic [47:0] in_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_data_byte,
	output logic [9:0]  out_offset,
	output logic        out_run_last,
	output logic        out_message_end,
	output logic        out_length_error
);

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIG_W  = $clog2(DIGITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	logic [1:0]          op_q;
	logic [47:0]         val_q;
	logic [3:0]          fp_q;
	logic                pre_q;
	logic [9:0]          count_q;
	logic [7:0]          sum_q;
	logic                ovf_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [DIGITS*4-1:0] bcd_q;
	logic [DIGITS*4-1:0] adj;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIG_W-1:0]    idx_q;
	logic [63:0]         src64;
	logic [3:0]          digit;
	logic [7:0]          new_byte;
	logic [9:0]          new_off;
	logic                blocked;
	logic                do_push;
	logic                move;

	logic       hold_valid_q;
	logic [7:0] hold_byte_q;
	logic [9:0] hold_off_q;
	logic       hold_end_q;
	logic       hold_err_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [9:0] out_off_q;
	logic       out_last_q;
	logic       out_end_q;
	logic       out_err_q;

	always_comb begin
		case (cmd.conv_sel)
			CV_NUM:   src64 = {32'd0, val_q[31:0]};
			CV_PRICE: src64 = {16'd0, val_q};
			CV_LEN:   src64 = {54'd0, count_q};
			default:  src64 = {56'd0, sum_q};
		endcase
	end

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	assign digit = bcd_q[{idx_q, 2'b00} +: 4];

	always_comb begin
		case (cmd.byte_src)
			BS_INPUT: new_byte = val_q[7:0];
			BS_DIGIT: new_byte = {4'h3, digit};
			default:  new_byte = cmd.const_byte;
		endcase
		case (cmd.off_src)
			OS_BODY:  new_off = HEADER_BYTES + count_q;
			OS_TRAIL: new_off = HEADER_BYTES + count_q + cmd.off_k;
			default:  new_off = cmd.off_k;
		endcase
	end

	assign blocked = cmd.is_body && (ovf_q || count_q >= BODY_MAX);
	assign do_push = cmd.push && !blocked;
	assign move    = hold_valid_q && (do_push || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= FP_SENDER;
			pre_q   <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			op_q    <= OP_TEXT;
		end else begin
			if (cmd.latch_in) begin
				op_q <= in_opcode;
			end
			if (cmd.push && blocked) begin
				ovf_q <= 1'b1;
			end
			if (do_push && cmd.is_body) begin
				count_q <= count_q + 10'd1;
			end
			if (do_push && (cmd.is_body || cmd.add_sum)) begin
				sum_q <= sum_q + new_byte;
			end
			if (cmd.fp_inc) begin
				fp_q <= fp_q + 4'd1;
			end
			if (cmd.prefix_set) begin
				pre_q <= 1'b1;
			end
			if (cmd.prefix_clr) begin
				pre_q <= 1'b0;
			end
			if (cmd.clr_msg) begin
				fp_q    <= FP_SENDER;
				pre_q   <= 1'b0;
				count_q <= '0;
				sum_q   <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.conv_start) begin
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.dig_init) begin
				idx_q <= DIG_W'(DIGITS - 1);
			end else if (cmd.dig_dec) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			val_q <= in_value;
		end
		if (cmd.conv_start) begin
			bin_q <= src64[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[DIGITS*4-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// one result is held back so run_last can be set when the item closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (do_push) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			hold_byte_q <= new_byte;
			hold_off_q  <= new_off;
			hold_end_q  <= cmd.msg_end;
			hold_err_q  <= cmd.len_err;
		end
		if (move) begin
			out_byte_q <= hold_byte_q;
			out_off_q  <= hold_off_q;
			out_end_q  <= hold_end_q;
			out_err_q  <= hold_err_q;
			out_last_q <= cmd.flush;
		end
	end

	always_comb begin
		st                = '0;
		st.can_push       = !hold_valid_q || !out_valid_q || out_ready;
		st.hold_valid     = hold_valid_q;
		st.conv_busy      = cnt_q != '0;
		st.opcode         = op_q;
		st.fp             = fp_q;
		st.prefix_written = pre_q;
		st.overflow       = ovf_q;
		st.count_lt_min   = count_q < BODY_MIN;
		st.digit          = digit;
		st.idx_zero       = idx_q == '0;
		st.idx_le2        = idx_q <= DIG_W'(2);
		st.idx_le4        = idx_q <= DIG_W'(4);
		st.idx_eq4        = idx_q == DIG_W'(4);
	end

	assign out_valid        = out_valid_q;
	assign out_data_byte    = out_byte_q;
	assign out_offset       = out_off_q;
	assign out_run_last     = out_last_q;
	assign out_message_end  = out_end_q;
	assign out_length_error = out_err_q;

endmodule

@@ rtl/core/foe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foe_ctrl
// Sequencer: decodes each item and steps through prefix, value, header and
// trailer bytes.
// ----------------------------------------------------------------------------
module foe_ctrl
	import foe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  foe_status_t st,
	output foe_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ERROR, S_PRE, S_BODYOP, S_ADV, S_FIN, S_HDR,
		S_CONV, S_DIG, S_DOT, S_HSOH, S_CKC, S_TR, S_TSOH, S_FLUSH
	} state_t;

	state_t    state_q, state_d;
	logic [3:0] step_q, step_d;
	conv_sel_t purpose_q, purpose_d;
	logic      started_q, started_d;
	kind_t     kind;
	logic      bad;
	logic      min_ok;
	logic      show;

	assign kind   = kind_of(st.fp);
	assign bad    = (st.opcode == OP_ILLEGAL) ||
		((kind == KIND_TEXT) != (st.opcode != OP_VALUE));
	assign min_ok = (purpose_q == CV_PRICE) ? st.idx_le4
		: ((purpose_q == CV_NUM) ? st.idx_zero : st.idx_le2);
	assign show   = started_q || (st.digit != 4'd0) || min_ok;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_d   = state_q;
		step_d    = step_q;
		purpose_d = purpose_q;
		started_d = started_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (bad) begin
					state_d = S_ERROR;
				end else if (!st.prefix_written) begin
					state_d = S_PRE;
					step_d  = (st.fp == FP_SENDER || st.fp == FP_SYMBOL) ? 4'd0 : 4'd5;
				end else begin
					state_d = S_BODYOP;
				end
			end
			S_ERROR: begin
				if (st.can_push) begin
					cmd.push     = 1'b1;
					cmd.off_src  = OS_FIXED;
					cmd.msg_end  = 1'b1;
					cmd.len_err  = 1'b1;
					cmd.clr_msg  = 1'b1;
					state_d      = S_FLUSH;
				end
			end
			S_PRE: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.is_body    = 1'b1;
					cmd.const_byte = pre_char(st.fp, step_q[2:0]);
					if (step_q == 4'd7) begin
						cmd.prefix_set = 1'b1;
						state_d        = S_BODYOP;
					end else begin
						step_d = step_q + 4'd1;
					end
				end
			end
			S_BODYOP: begin
				if (st.opcode == OP_END) begin
					state_d = S_ADV;
				end else if (st.opcode == OP_TEXT || kind == KIND_CHAR) begin
					if (st.can_push) begin
						cmd.push     = 1'b1;
						cmd.is_body  = 1'b1;
						cmd.byte_src = BS_INPUT;
						state_d      = (st.opcode == OP_TEXT) ? S_FLUSH : S_ADV;
					end
				end else begin
					cmd.conv_start = 1'b1;
					cmd.conv_sel   = (kind == KIND_PRICE) ? CV_PRICE : CV_NUM;
					purpose_d      = cmd.conv_sel;
					state_d        = S_CONV;
				end
			end
			S_ADV: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.is_body    = 1'b1;
					cmd.const_byte = CH_SOH;
					cmd.prefix_clr = 1'b1;
					if (st.fp == FP_LAST) begin
						state_d = S_FIN;
					end else begin
						cmd.fp_inc = 1'b1;
						state_d    = S_FLUSH;
					end
				end
			end
			S_FIN: begin
				if (st.overflow || st.count_lt_min) begin
					state_d = S_ERROR;
				end else begin
					cmd.conv_start = 1'b1;
					cmd.conv_sel   = CV_LEN;
					purpose_d      = CV_LEN;
					step_d         = 4'd0;
					state_d        = S_HDR;
				end
			end
			S_HDR: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.add_sum    = 1'b1;
					cmd.off_src    = OS_FIXED;
					cmd.off_k      = {6'd0, step_q};
					cmd.const_byte = head_char(step_q);
					if (step_q == 4'd11) begin
						state_d = S_CONV;
					end else begin
						step_d = step_q + 4'd1;
					end
				end
			end
			S_CONV: begin
				if (!st.conv_busy) begin
					cmd.dig_init = 1'b1;
					started_d    = 1'b0;
					step_d       = 4'd0;
					state_d      = S_DIG;
				end
			end
			S_DIG: begin
				if (st.can_push) begin
					if (show) begin
						cmd.push     = 1'b1;
						cmd.byte_src = BS_DIGIT;
						started_d    = 1'b1;
						step_d       = step_q + 4'd1;
						case (purpose_q)
							CV_LEN: begin
								cmd.off_src = OS_FIXED;
								cmd.off_k   = OFF_LEN + {6'd0, step_q};
								cmd.add_sum = 1'b1;
							end
							CV_CK: begin
								cmd.off_src = OS_TRAIL;
								cmd.off_k   = OFF_CK + {6'd0, step_q};
							end
							default: begin
								cmd.is_body = 1'b1;
							end
						endcase
					end
					if (purpose_q == CV_PRICE && st.idx_eq4) begin
						cmd.dig_dec = 1'b1;
						state_d     = S_DOT;
					end else if (st.idx_zero) begin
						case (purpose_q)
							CV_LEN:  state_d = S_HSOH;
							CV_CK:   state_d = S_TSOH;
							default: state_d = S_ADV;
						endcase
					end else begin
						cmd.dig_dec = 1'b1;
					end
				end
			end
			S_DOT: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.is_body    = 1'b1;
					cmd.const_byte = CH_DOT;
					state_d        = S_DIG;
				end
			end
			S_HSOH: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.add_sum    = 1'b1;
					cmd.off_src    = OS_FIXED;
					cmd.off_k      = OFF_HSOH;
					cmd.const_byte = CH_SOH;
					state_d        = S_CKC;
				end
			end
			S_CKC: begin
				cmd.conv_start = 1'b1;
				cmd.conv_sel   = CV_CK;
				purpose_d      = CV_CK;
				step_d         = 4'd0;
				state_d        = S_TR;
			end
			S_TR: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.off_src    = OS_TRAIL;
					cmd.off_k      = {6'd0, step_q};
					cmd.const_byte = trail_char(step_q);
					if (step_q == 4'd2) begin
						state_d = S_CONV;
					end else begin
						step_d = step_q + 4'd1;
					end
				end
			end
			S_TSOH: begin
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.off_src    = OS_TRAIL;
					cmd.off_k      = OFF_TSOH;
					cmd.const_byte = CH_SOH;
					cmd.msg_end    = 1'b1;
					cmd.clr_msg    = 1'b1;
					state_d        = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!st.hold_valid) begin
					state_d = S_IDLE;
				end else if (st.can_push) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			purpose_q <= CV_NUM;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			step_q    <= step_d;
			purpose_q <= purpose_d;
			started_q <= started_d;
		end
	end

endmodule

@@ test/fix_order_message_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fix_order_message_encoder_tb
// Feeds order messages field by field into the encoder and compares every
// wire byte, offset and flag against an encoder model held in the bench.
// Covers wrong opcodes, empty fields, the lower body length limit, random
// values and a long output stall, with random idling on both channels.
// ----------------------------------------------------------------------------
module fix_order_message_encoder_tb;
	import foe_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [9:0] offset;
		logic       run_last;
		logic       message_end;
		logic       length_error;
	} wire_byte_t;

	logic clk;
	logic arst_n;
	foe_in_if  in_ch ();
	foe_out_if out_ch ();

	fix_order_message_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (in_ch),
		.item_out (out_ch)
	);

	// encoder model state
	logic [3:0]   m_field;
	bit           m_prefix_done;
	int unsigned  m_body_len;
	logic [7:0]   m_body_sum;
	bit           m_overflow;
	wire_byte_t   step_bytes[$];
	wire_byte_t   pending_bytes[$];

	int  errors;
	int  stall_cycles;
	bit  no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("fix_order_message_encoder_tb: FAIL");
		$finish;
	end

	function automatic bit field_is_text(input logic [3:0] f);
		return !(f == 4'd2 || f == 4'd6 || f == 4'd8 || f == 4'd9 || f == 4'd10 || f == 4'd11);
	endfunction

	function automatic int unsigned field_tag(input logic [3:0] f);
		int unsigned tags[12] = '{49, 56, 34, 52, 11, 55, 54, 60, 38, 40, 44, 59};
		return tags[f];
	endfunction

	function automatic void emit(input logic [7:0] b, input int unsigned off,
			input bit en, input bit er);
		wire_byte_t w;
		if (step_bytes.size() >= 28)
			return;
		w.data_byte = b;
		w.offset = off[9:0];
		w.run_last = 1'b0;
		w.message_end = en;
		w.length_error = er;
		step_bytes.push_back(w);
	endfunction

	function automatic void reset_message();
		m_field = FP_SENDER;
		m_prefix_done = 0;
		m_body_len = 0;
		m_body_sum = 8'd0;
		m_overflow = 0;
	endfunction

	function automatic void body_byte(input logic [7:0] b);
		if (m_overflow || m_body_len >= 999) begin
			m_overflow = 1;
			return;
		end
		emit(b, 16 + m_body_len, 0, 0);
		m_body_len++;
		m_body_sum = m_body_sum + b;
	endfunction

	function automatic void body_decimal(input logic [63:0] v, input int min_digits);
		logic [7:0] d[$];
		logic [63:0] x;
		x = v;
		do begin
			d.push_front(8'd48 + 8'(x % 10));
			x = x / 10;
		end while (x != 0);
		while (d.size() < min_digits)
			d.push_front("0");
		foreach (d[i])
			body_byte(d[i]);
	endfunction

	function automatic void field_prefix();
		if (m_prefix_done)
			return;
		if (m_field == FP_SENDER) begin
			body_byte("3"); body_byte("5"); body_byte("="); body_byte("D"); body_byte(CH_SOH);
		end
		if (m_field == FP_SYMBOL) begin
			body_byte("2"); body_byte("1"); body_byte("="); body_byte("1"); body_byte(CH_SOH);
		end
		body_decimal(field_tag(m_field), 1);
		body_byte("=");
		m_prefix_done = 1;
	endfunction

	function automatic void close_message();
		string       hdr;
		int unsigned sum;
		int unsigned ck;
		int unsigned off;
		logic [7:0]  dg[3];
		hdr = "8=FIX.4.4\0019=";
		if (m_overflow || m_body_len < 100) begin
			emit(8'd0, 0, 1, 1);
			reset_message();
			return;
		end
		sum = m_body_sum;
		for (int i = 0; i < 12; i++) begin
			emit(hdr[i], i, 0, 0);
			sum += hdr[i];
		end
		dg[0] = 8'd48 + 8'(m_body_len / 100);
		dg[1] = 8'd48 + 8'((m_body_len / 10) % 10);
		dg[2] = 8'd48 + 8'(m_body_len % 10);
		for (int i = 0; i < 3; i++) begin
			emit(dg[i], 12 + i, 0, 0);
			sum += dg[i];
		end
		emit(CH_SOH, 15, 0, 0);
		sum += CH_SOH;
		ck = sum % 256;
		off = 16 + m_body_len;
		emit("1", off, 0, 0);
		emit("0", off + 1, 0, 0);
		emit("=", off + 2, 0, 0);
		emit(8'd48 + 8'(ck / 100), off + 3, 0, 0);
		emit(8'd48 + 8'((ck / 10) % 10), off + 4, 0, 0);
		emit(8'd48 + 8'(ck % 10), off + 5, 0, 0);
		emit(CH_SOH, off + 6, 1, 0);
		reset_message();
	endfunction

	function automatic void next_field();
		body_byte(CH_SOH);
		m_prefix_done = 0;
		if (m_field == FP_LAST)
			close_message();
		else
			m_field++;
	endfunction

	function automatic void encode_item(input logic [1:0] op, input logic [47:0] val);
		bit text;
		logic [47:0] px;
		text = field_is_text(m_field);
		step_bytes.delete();
		if (op == OP_ILLEGAL || text != (op != OP_VALUE)) begin
			emit(8'd0, 0, 1, 1);
			reset_message();
		end else if (op == OP_TEXT) begin
			field_prefix();
			body_byte(val[7:0]);
		end else if (op == OP_END) begin
			field_prefix();
			next_field();
		end else begin
			field_prefix();
			if (m_field == 4'd2 || m_field == 4'd8) begin
				body_decimal({32'd0, val[31:0]}, 1);
			end else if (m_field == 4'd10) begin
				px = val;
				body_decimal({16'd0, px} / 10000, 1);
				body_byte(".");
				body_decimal({16'd0, px} % 10000, 4);
			end else begin
				body_byte(val[7:0]);
			end
			next_field();
		end
		if (step_bytes.size() > 0)
			step_bytes[step_bytes.size() - 1].run_last = 1'b1;
		foreach (step_bytes[i])
			pending_bytes.push_back(step_bytes[i]);
	endfunction

	task automatic report(input string what);
		if (errors < 40)
			$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// sender: valid stays high between back-to-back items
	task automatic send_item(input logic [1:0] op, input logic [47:0] val);
		if (!no_idle && $urandom_range(99) < 30) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.value  <= val;
		do @(posedge clk); while (!in_ch.ready);
		encode_item(op, val);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [47:0] rand_number();
		case ($urandom_range(3))
			0: return {16'($urandom), 32'd0};
			1: return {16'($urandom), 32'hFFFF_FFFF};
			2: return 48'($urandom_range(999));
			default: return rand48();
		endcase
	endfunction

	function automatic logic [47:0] rand_price();
		case ($urandom_range(3))
			0: return 48'd0;
			1: return 48'hFFFF_FFFF_FFFF;
			2: return 48'($urandom_range(9_999_999));
			default: return rand48();
		endcase
	endfunction

	// one message; first field first_len bytes, other text fields min..max
	task automatic send_message(input int first_len, input int min_len, input int max_len,
			input bit zero_vals);
		int n;
		for (int f = 0; f < 12; f++) begin
			if (field_is_text(4'(f))) begin
				n = (f == 0) ? first_len : $urandom_range(max_len, min_len);
				repeat (n) send_item(OP_TEXT, rand48());
				send_item(OP_END, rand48());
			end else if (f == 10) begin
				send_item(OP_VALUE, zero_vals ? 48'd0 : rand_price());
			end else if (f == 2 || f == 8) begin
				send_item(OP_VALUE, zero_vals ? 48'd0 : rand_number());
			end else begin
				send_item(OP_VALUE, rand48());
			end
		end
	endtask

	task automatic test_wrong_opcodes();
		send_item(OP_VALUE, rand48());
		send_item(OP_ILLEGAL, rand48());
		send_item(OP_TEXT, rand48());
		send_item(OP_ILLEGAL, rand48());
		send_item(OP_END, rand48());
		send_item(OP_END, rand48());
		send_item(OP_TEXT, rand48());
		send_item(OP_END, rand48());
		send_item(OP_END, rand48());
		send_item(OP_END, rand48());
		send_item(OP_TEXT, rand48());
		send_item(OP_ILLEGAL, rand48());
	endtask

	// zero values and empty fields: 30 sender bytes give a 99-byte body
	task automatic test_body_limits();
		send_message(30, 0, 0, 1);
	endtask

	// 31 sender bytes give the shortest legal body, 100 bytes
	task automatic test_no_idle();
		no_idle = 1;
		send_message(31, 0, 0, 1);
		no_idle = 0;
	endtask

	task automatic test_output_stall();
		stall_cycles = 400;
		send_message(12, 0, 3, 0);
	endtask

	initial begin : receiver
		wire_byte_t got;
		wire_byte_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.data_byte = out_ch.data_byte;
				got.offset = out_ch.offset;
				got.run_last = out_ch.run_last;
				got.message_end = out_ch.message_end;
				got.length_error = out_ch.length_error;
				if (pending_bytes.size() == 0) begin
					report($sformatf("unexpected byte %h off %0d", got.data_byte, got.offset));
				end else begin
					want = pending_bytes.pop_front();
					if (got.data_byte != want.data_byte)
						report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
					if (got.offset != want.offset)
						report($sformatf("offset %0d, want %0d", got.offset, want.offset));
					if (got.run_last != want.run_last)
						report($sformatf("run_last %b off %0d", got.run_last, want.offset));
					if (got.message_end != want.message_end)
						report($sformatf("message_end %b off %0d", got.message_end, want.offset));
					if (got.length_error != want.length_error)
						report($sformatf("length_error %b off %0d", got.length_error, want.offset));
				end
			end
			if (stall_cycles > 0) begin
				stall_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin
		errors = 0;
		stall_cycles = 0;
		no_idle = 0;
		reset_message();
		arst_n = 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.opcode <= OP_TEXT;
		in_ch.value  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wrong_opcodes();
		test_body_limits();
		test_no_idle();
		test_output_stall();
		@(posedge clk);
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0)
			$display("fix_order_message_encoder_tb: PASS");
		else
			$display("fix_order_message_encoder_tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/foe_pkg.sv
rtl/core/foe_if.sv
rtl/core/foe_dpath.sv
rtl/core/foe_ctrl.sv
rtl/core/fix_order_message_encoder.sv
test/fix_order_message_encoder_tb.sv
